@@ sv/assert_macros.svh @@
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error(msg);

`endif

@@ sv/tcrb_pkg.sv @@
package tcrb_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned StampW = 32;
  localparam int unsigned LenW   = 12;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_STATUS = 2'd2,
    CMD_OTHER  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_UNUSED = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WDATA,
    S_WHDR,
    S_RHDR,
    S_RWAIT,
    S_RLOAD,
    S_RDATA,
    S_RDWAIT,
    S_RDDONE,
    S_SHDR,
    S_SWAIT,
    S_SLOAD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic       take_item;
    logic       mem_we;
    logic [1:0] addr_sel;
    logic [3:0] hdr_idx;
    logic       wr_data;
    logic       wr_commit;
    logic       hdr_cap;
    logic       rd_load;
    logic       rd_pop;
    logic       st_load;
    logic       set_status;
    status_e    status;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic    full;
    logic    empty;
    logic    loaded;
    logic    commit_now;
    logic    write_open;
    logic    hdr_last;
    cmd_e    cmd;
  } stat_t;

  localparam logic [1:0] ASEL_HDR  = 2'd0;
  localparam logic [1:0] ASEL_WDAT = 2'd1;
  localparam logic [1:0] ASEL_RDAT = 2'd2;
  localparam logic [1:0] ASEL_THDR = 2'd3;

endpackage

@@ sv/tcrb_in_if.sv @@
interface tcrb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  data_byte;
  logic [31:0] chunk_timestamp;
  logic        last_byte;
  modport source (output valid, command, data_byte, chunk_timestamp, last_byte, input ready);
  modport sink (input valid, command, data_byte, chunk_timestamp, last_byte, output ready);
endinterface

@@ sv/tcrb_out_if.sv @@
interface tcrb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_byte;
  logic [31:0] read_timestamp;
  logic        chunk_end;
  logic [1:0]  status;
  logic        is_empty;
  logic        is_full;
  modport source (output valid, read_byte, read_timestamp, chunk_end, status, is_empty,
                  is_full, input ready);
  modport sink (input valid, read_byte, read_timestamp, chunk_end, status, is_empty,
                is_full, output ready);
endinterface

@@ sv/tcrb_ram.sv @@
module tcrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

@@ sv/tcrb_ctrl.sv @@
module tcrb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tcrb_pkg::stat_t  stat_i,
  output tcrb_pkg::cmd_t   cmd_o
);
  import tcrb_pkg::*;
  `include "assert_macros.svh"

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign in_ready_o  = (state_q == S_IDLE);

  // next state
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cnt_d = '0;
          case (stat_i.cmd)
            CMD_WRITE: state_d = S_WDATA;
            CMD_READ:  state_d = S_RHDR;
            default:   state_d = S_SHDR;
          endcase
        end
      end
      S_WDATA: begin
        if (!stat_i.write_open && stat_i.full) state_d = S_OUT;
        else if (stat_i.commit_now) state_d = S_WHDR;
        else state_d = S_OUT;
      end
      S_WHDR: begin
        cnt_d = cnt_q + 4'd1;
        if (stat_i.hdr_last) state_d = S_OUT;
      end
      S_RHDR: begin
        if (stat_i.loaded) state_d = S_RDATA;
        else if (stat_i.empty) state_d = S_OUT;
        else state_d = S_RWAIT;
      end
      S_RWAIT: begin
        cnt_d = cnt_q + 4'd1;
        state_d = S_RLOAD;
      end
      S_RLOAD: begin
        if (cnt_q == 4'd6) state_d = S_RDATA;
        else state_d = S_RWAIT;
      end
      S_RDATA:  state_d = S_RDWAIT;
      S_RDWAIT: state_d = S_RDDONE;
      S_RDDONE: state_d = S_OUT;
      S_SHDR: begin
        if (stat_i.empty || stat_i.loaded) state_d = S_OUT;
        else state_d = S_SWAIT;
      end
      S_SWAIT: begin
        cnt_d = cnt_q + 4'd1;
        state_d = S_SLOAD;
      end
      S_SLOAD: begin
        if (cnt_q == 4'd4) state_d = S_OUT;
        else state_d = S_SWAIT;
      end
      S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.status = ST_DONE;
    cmd_o.hdr_idx = cnt_q;
    case (state_q)
      S_IDLE:  cmd_o.take_item = in_valid_i;
      S_WDATA: begin
        if (!stat_i.write_open && stat_i.full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = ST_FULL;
        end else begin
          cmd_o.addr_sel = ASEL_WDAT;
          cmd_o.mem_we = 1'b1;
          cmd_o.wr_data = 1'b1;
        end
      end
      S_WHDR: begin
        cmd_o.addr_sel = ASEL_HDR;
        cmd_o.mem_we = 1'b1;
        cmd_o.wr_commit = stat_i.hdr_last;
      end
      S_RHDR: begin
        if (!stat_i.loaded && stat_i.empty) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = ST_EMPTY;
        end
        cmd_o.addr_sel = ASEL_THDR;
      end
      S_RWAIT: cmd_o.addr_sel = ASEL_THDR;
      S_RLOAD: begin
        cmd_o.addr_sel = ASEL_THDR;
        cmd_o.hdr_cap = 1'b1;
        cmd_o.rd_load = (cnt_q == 4'd6);
      end
      S_RDATA:  cmd_o.addr_sel = ASEL_RDAT;
      S_RDWAIT: cmd_o.addr_sel = ASEL_RDAT;
      S_RDDONE: cmd_o.rd_pop = 1'b1;
      S_SHDR:   cmd_o.addr_sel = ASEL_THDR;
      S_SWAIT:  cmd_o.addr_sel = ASEL_THDR;
      S_SLOAD: begin
        cmd_o.addr_sel = ASEL_THDR;
        cmd_o.hdr_cap = 1'b1;
        cmd_o.st_load = (cnt_q == 4'd4);
      end
      S_OUT: cmd_o.out_load = !ovalid_q || out_ready_i;
      default: ;
    endcase
  end

  `ASSERT_NEXT(a_take_leaves_idle, in_valid_i && in_ready_o, state_q != S_IDLE,
               "item taken but still idle")
  `ASSERT_CLK(a_we_only_write, !cmd_o.mem_we || state_q == S_WDATA || state_q == S_WHDR,
              "store written outside a write")
  `ASSERT_NEXT(a_out_load_valid, cmd_o.out_load, out_valid_o, "result lost")
endmodule

@@ sv/tcrb_dp.sv @@
module tcrb_dp #(
  parameter int unsigned StoreBytes  = 65536,
  parameter int unsigned MaxPayload  = 4000,
  parameter int unsigned HeaderBytes = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [15:0]              cfg_wdata_i,
  input  logic [1:0]               command_i,
  input  logic [7:0]               data_byte_i,
  input  logic [31:0]              chunk_timestamp_i,
  input  logic                     last_byte_i,
  input  tcrb_pkg::cmd_t           cmd_i,
  output tcrb_pkg::stat_t          stat_o,
  output logic [7:0]               read_byte_o,
  output logic [31:0]              read_timestamp_o,
  output logic                     chunk_end_o,
  output logic [1:0]               status_o,
  output logic                     is_empty_o,
  output logic                     is_full_o
);
  import tcrb_pkg::*;

  localparam int unsigned AW = $clog2(StoreBytes);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned ChunkBytes = HeaderBytes + MaxPayload;
  localparam int unsigned CapMax = StoreBytes - ChunkBytes + 1;
  localparam logic [IW-1:0] ChunkI = IW'(ChunkBytes);
  localparam logic [IW-1:0] HdrI = IW'(HeaderBytes);
  localparam logic [LenW-1:0] MaxL = LenW'(MaxPayload);

  logic [15:0]       cap_q;
  logic [IW-1:0]     head_q, tail_q, cap_eff;
  logic [LenW-1:0]   fill_q, rem_q;
  logic              wopen_q, loaded_q;
  logic [StampW-1:0] rstamp_q, hstamp_q;
  logic [7:0]        hlen_q;
  logic [1:0]        cmdr_q;
  logic [7:0]        datr_q;
  logic [31:0]       tsr_q;
  logic              lastr_q;
  logic [1:0]        stat_q;
  logic [7:0]        rbyte_q;
  logic              rend_q;
  logic [7:0]        ob_q;
  logic [31:0]       ots_q;
  logic              oend_q;
  logic [1:0]        ost_q;
  logic              oemp_q, ofull_q;

  logic [AW-1:0] addr;
  logic [7:0]    wdata, rdata;
  logic [IW-1:0] addr_w;
  logic [LenW-1:0] fill_n;
  logic [LenW-1:0] len_c;
  logic          full_c, empty_c;

  always_comb begin
    cap_eff = IW'(cap_q);
    if (cap_q == 16'd0) cap_eff = IW'(1);
    if (IW'(cap_q) > IW'(CapMax)) cap_eff = IW'(CapMax);
  end

  assign empty_c = (head_q == tail_q);
  assign full_c  = (head_q >= cap_eff) ||
                   ((head_q < tail_q) && ((tail_q - head_q) <= ChunkI));
  assign fill_n  = fill_q + LenW'(1);

  always_comb begin
    case (cmd_i.addr_sel)
      ASEL_HDR:  addr_w = head_q + IW'(cmd_i.hdr_idx);
      ASEL_WDAT: addr_w = head_q + HdrI + IW'(fill_q);
      ASEL_RDAT: addr_w = tail_q + HdrI;
      default:   addr_w = tail_q + IW'(cmd_i.hdr_idx);
    endcase
    addr = addr_w[AW-1:0];
  end

  always_comb begin
    case (cmd_i.hdr_idx)
      4'd0:    wdata = tsr_q[7:0];
      4'd1:    wdata = tsr_q[15:8];
      4'd2:    wdata = tsr_q[23:16];
      4'd3:    wdata = tsr_q[31:24];
      4'd4:    wdata = fill_q[7:0];
      4'd5:    wdata = {4'd0, fill_q[11:8]};
      default: wdata = 8'd0;
    endcase
    if (cmd_i.wr_data) wdata = datr_q;
  end

  tcrb_ram #(.Width(8), .Depth(StoreBytes)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we && !addr_w[IW-1]),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // length low byte was captured, high nibble is on the read port now
  always_comb begin
    len_c = {rdata[3:0], hlen_q};
    if (len_c == '0) len_c = LenW'(1);
    if (len_c > MaxL) len_c = MaxL;
  end

  assign stat_o.full       = full_c;
  assign stat_o.empty      = empty_c;
  assign stat_o.loaded     = loaded_q;
  assign stat_o.commit_now = lastr_q || (fill_n >= MaxL);
  assign stat_o.write_open = wopen_q;
  assign stat_o.hdr_last   = (cmd_i.hdr_idx == 4'(HeaderBytes - 1));
  assign stat_o.cmd        = cmd_e'(command_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      cmdr_q  <= command_i;
      datr_q  <= data_byte_i;
      tsr_q   <= chunk_timestamp_i;
      lastr_q <= last_byte_i;
      rbyte_q <= '0;
      rend_q  <= 1'b0;
    end
    if (cmd_i.hdr_cap) begin
      // header bytes 0..4 arrive one index behind hdr_idx, each into its field
      case (cmd_i.hdr_idx)
        4'd1: hstamp_q[7:0]   <= rdata;
        4'd2: hstamp_q[15:8]  <= rdata;
        4'd3: hstamp_q[23:16] <= rdata;
        4'd4: hstamp_q[31:24] <= rdata;
        4'd5: hlen_q          <= rdata;
        default: ;
      endcase
    end
    if (cmd_i.rd_pop) begin
      rbyte_q <= rdata;
      rend_q  <= (rem_q == LenW'(1));
    end
    if (cmd_i.out_load) begin
      ob_q    <= rbyte_q;
      oend_q  <= rend_q;
      ost_q   <= stat_q;
      oemp_q  <= empty_c;
      ofull_q <= full_c;
      if (stat_q != 2'(ST_DONE) || cmdr_q == 2'(CMD_WRITE)) ots_q <= '0;
      else if (cmdr_q == 2'(CMD_READ)) ots_q <= rstamp_q;
      else if (empty_c) ots_q <= '0;
      else if (loaded_q) ots_q <= rstamp_q;
      else ots_q <= hstamp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= 16'd61529;
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      wopen_q  <= 1'b0;
      rem_q    <= '0;
      loaded_q <= 1'b0;
      rstamp_q <= '0;
      stat_q   <= '0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (cmd_i.take_item) stat_q <= 2'(ST_DONE);
      if (cmd_i.set_status) stat_q <= 2'(cmd_i.status);
      if (cmd_i.wr_data) begin
        fill_q  <= fill_n;
        wopen_q <= 1'b1;
      end
      if (cmd_i.wr_commit) begin
        if ((head_q + HdrI + IW'(fill_q) >= cap_eff) && (tail_q >= ChunkI)) head_q <= '0;
        else head_q <= head_q + HdrI + IW'(fill_q);
        wopen_q <= 1'b0;
        fill_q  <= '0;
      end
      if (cmd_i.rd_load) begin
        rem_q    <= len_c;
        rstamp_q <= hstamp_q;
        loaded_q <= 1'b1;
      end
      if (cmd_i.rd_pop) begin
        rem_q <= rem_q - LenW'(1);
        if (rem_q == LenW'(1)) begin
          loaded_q <= 1'b0;
          if (tail_q + HdrI + IW'(1) >= cap_eff) begin
            tail_q <= '0;
            if (head_q >= cap_eff) head_q <= '0;
          end else begin
            tail_q <= tail_q + HdrI + IW'(1);
            if ((head_q >= cap_eff) && (tail_q + HdrI + IW'(1) >= ChunkI)) head_q <= '0;
          end
        end else begin
          tail_q <= tail_q + IW'(1);
          if ((head_q >= cap_eff) && (tail_q + IW'(1) >= ChunkI)) head_q <= '0;
        end
      end
    end
  end

  assign read_byte_o      = ob_q;
  assign read_timestamp_o = ots_q;
  assign chunk_end_o      = oend_q;
  assign status_o         = ost_q;
  assign is_empty_o       = oemp_q;
  assign is_full_o        = ofull_q;
endmodule

@@ sv/timestamped_chunk_ring_buffer_unit.sv @@
// channel  dir  payload
// in       in   command, data_byte, chunk_timestamp, last_byte
// out      out  read_byte, read_timestamp, chunk_end, status, is_empty, is_full
// cfg      in   cfg_we_i, cfg_wdata_i (capacity)
// a write item that closes a chunk also writes the header, one byte per cycle
// a read item loads the tail header when none is loaded; a read of an empty ring is rejected
// the single store port serves every item; one item in flight at a time
// output register holds a result while the next item is worked on
module timestamped_chunk_ring_buffer_unit #(
  parameter int unsigned STORE_BYTES  = 65536,
  parameter int unsigned MAX_PAYLOAD  = 4000,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  tcrb_in_if.sink     in_if,
  tcrb_out_if.source  out_if
);
  import tcrb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tcrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tcrb_dp #(
    .StoreBytes  (STORE_BYTES),
    .MaxPayload  (MAX_PAYLOAD),
    .HeaderBytes (HEADER_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .command_i         (in_if.command),
    .data_byte_i       (in_if.data_byte),
    .chunk_timestamp_i (in_if.chunk_timestamp),
    .last_byte_i       (in_if.last_byte),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .read_byte_o       (out_if.read_byte),
    .read_timestamp_o  (out_if.read_timestamp),
    .chunk_end_o       (out_if.chunk_end),
    .status_o          (out_if.status),
    .is_empty_o        (out_if.is_empty),
    .is_full_o         (out_if.is_full)
  );
endmodule

@@ verif/tcrb_checker.sv @@
`timescale 1ns / 100ps

module tcrb_checker
  import tcrb_pkg::*;
#(
  parameter int unsigned MaxPayload  = 4000,
  parameter int unsigned HeaderBytes = 8,
  parameter int unsigned StoreBytes  = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  tcrb_in_if          in_mon,
  tcrb_out_if         out_mon,
  output int          errors_o,
  output int          pending_o,
  output logic        drained_o,
  output logic        write_open_o
);

  localparam int unsigned ChunkBytes = HeaderBytes + MaxPayload;
  localparam int unsigned CapMax     = StoreBytes - ChunkBytes + 1;

  typedef struct packed {
    logic [7:0]  rbyte;
    logic [31:0] rstamp;
    logic        rend;
    status_e     status;
    logic        empty;
    logic        full;
  } ring_result_t;

  logic [7:0]   ring_mem [StoreBytes];
  int unsigned  cap_reg;
  int unsigned  head;
  int unsigned  tail;
  int unsigned  fill;
  logic         wr_open;
  int unsigned  rd_left;
  logic         rd_loaded;
  logic [31:0]  rd_stamp;
  ring_result_t expected_q[$];
  int           mismatches;

  function automatic int unsigned cap_now();
    if (cap_reg < 1) return 1;
    if (cap_reg > CapMax) return CapMax;
    return cap_reg;
  endfunction

  function automatic logic [7:0] mem_rd(int unsigned a);
    return (a < StoreBytes) ? ring_mem[a] : 8'd0;
  endfunction

  function automatic void mem_wr(int unsigned a, logic [7:0] v);
    if (a < StoreBytes) ring_mem[a] = v;
  endfunction

  function automatic logic [31:0] stamp_at(int unsigned a);
    return {mem_rd(a + 3), mem_rd(a + 2), mem_rd(a + 1), mem_rd(a)};
  endfunction

  function automatic logic ring_full();
    return head >= cap_now() || (head < tail && tail - head <= ChunkBytes);
  endfunction

  function automatic void head_wrap();
    if (head >= cap_now() && tail >= ChunkBytes) head = 0;
  endfunction

  function automatic ring_result_t ring_step(cmd_e cmd, logic [7:0] data,
                                             logic [31:0] stamp, logic last);
    ring_result_t r;
    int unsigned  len;
    r = '0;
    r.status = ST_DONE;
    if (cmd == CMD_WRITE) begin
      if (!wr_open && ring_full()) begin
        r.status = ST_FULL;
      end else begin
        if (!wr_open) begin
          wr_open = 1'b1;
          fill = 0;
        end
        mem_wr(head + HeaderBytes + fill, data);
        fill++;
        if (last || fill >= MaxPayload) begin
          mem_wr(head, stamp[7:0]);
          mem_wr(head + 1, stamp[15:8]);
          mem_wr(head + 2, stamp[23:16]);
          mem_wr(head + 3, stamp[31:24]);
          mem_wr(head + 4, fill[7:0]);
          mem_wr(head + 5, {4'd0, fill[11:8]});
          head += HeaderBytes + fill;
          head_wrap();
          wr_open = 1'b0;
          fill = 0;
        end
      end
    end else if (cmd == CMD_READ) begin
      if (!rd_loaded) begin
        if (head == tail) begin
          r.status = ST_EMPTY;
        end else begin
          len = {mem_rd(tail + 5) & 8'h0f, mem_rd(tail + 4)};
          if (len < 1) len = 1;
          if (len > MaxPayload) len = MaxPayload;
          rd_stamp = stamp_at(tail);
          rd_left = len;
          rd_loaded = 1'b1;
        end
      end
      if (rd_loaded) begin
        r.rbyte = mem_rd(tail + HeaderBytes);
        r.rstamp = rd_stamp;
        rd_left--;
        if (rd_left == 0) begin
          r.rend = 1'b1;
          rd_loaded = 1'b0;
          tail += HeaderBytes + 1;
          if (tail >= cap_now()) begin
            tail = 0;
            if (head >= cap_now()) head = 0;
          end
        end else begin
          tail++;
        end
        head_wrap();
      end
    end else begin
      if (head != tail) r.rstamp = rd_loaded ? rd_stamp : stamp_at(tail);
    end
    r.empty = (head == tail);
    r.full = ring_full();
    return r;
  endfunction

  assign pending_o    = expected_q.size();
  assign drained_o    = (head == tail) && !wr_open;
  assign write_open_o = wr_open;
  assign errors_o     = mismatches;

  initial begin
    foreach (ring_mem[i]) ring_mem[i] = 8'd0;
    cap_reg = 61529;
    head = 0;
    tail = 0;
    fill = 0;
    wr_open = 1'b0;
    rd_left = 0;
    rd_loaded = 1'b0;
    rd_stamp = '0;
    mismatches = 0;
  end

  always @(posedge clk_i) begin
    ring_result_t exp_r;
    ring_result_t got_r;
    if (rst_ni) begin
      if (cfg_we_i) cap_reg = cfg_wdata_i;
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(ring_step(cmd_e'(in_mon.command), in_mon.data_byte,
                                       in_mon.chunk_timestamp, in_mon.last_byte));
      end
      if (out_mon.valid && out_mon.ready) begin
        got_r.rbyte  = out_mon.read_byte;
        got_r.rstamp = out_mon.read_timestamp;
        got_r.rend   = out_mon.chunk_end;
        got_r.status = status_e'(out_mon.status);
        got_r.empty  = out_mon.is_empty;
        got_r.full   = out_mon.is_full;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("checker: unexpected beat %h", got_r);
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("checker: mismatch byte %h/%h stamp %h/%h end %b/%b",
                       exp_r.rbyte, got_r.rbyte, exp_r.rstamp, got_r.rstamp,
                       exp_r.rend, got_r.rend);
              $display("checker:   status %0d/%0d empty %b/%b full %b/%b",
                       exp_r.status, got_r.status, exp_r.empty, got_r.empty,
                       exp_r.full, got_r.full);
            end
          end
        end
      end
    end
  end

  final begin
    if (expected_q.size() != 0) $display("checker: %0d beats never came", expected_q.size());
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import tcrb_pkg::*;

  localparam int CycleLimit = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  int          errors;
  int          pending;
  logic        drained;
  logic        wr_open;
  int          tx_idle;
  int          rx_idle;
  int          cycles = 0;

  tcrb_in_if  in_if ();
  tcrb_out_if out_if ();

  timestamped_chunk_ring_buffer_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_if(in_if), .out_if(out_if)
  );

  tcrb_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_mon(in_if), .out_mon(out_if), .errors_o(errors), .pending_o(pending),
    .drained_o(drained), .write_open_o(wr_open)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_if.ready <= ($urandom_range(99) >= rx_idle);
    else out_if.ready <= 1'b0;
  end

  task automatic send_item(cmd_e cmd, logic [7:0] data, logic [31:0] stamp, logic last);
    if ($urandom_range(99) < tx_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.data_byte <= data;
    in_if.chunk_timestamp <= stamp;
    in_if.last_byte <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic drain_ring();
    settle();
    if (wr_open) begin
      send_item(CMD_WRITE, 8'($urandom), $urandom, 1'b1);
      settle();
    end
    while (!drained) begin
      send_item(CMD_READ, 8'($urandom), $urandom, 1'b0);
      settle();
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [15:0] cap);
    drain_ring();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_items(int count);
    int   pick;
    cmd_e cmd;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) cmd = CMD_WRITE;
      else if (pick < 85) cmd = CMD_READ;
      else if (pick < 95) cmd = CMD_STATUS;
      else cmd = CMD_OTHER;
      send_item(cmd, 8'($urandom), $urandom, ($urandom_range(5) == 0));
    end
  endtask

  initial begin
    logic [15:0] caps [3];
    int          waited;
    in_if.valid = 1'b0;
    in_if.command = CMD_STATUS;
    in_if.data_byte = '0;
    in_if.chunk_timestamp = '0;
    in_if.last_byte = 1'b0;
    tx_idle = 24;
    rx_idle = 52;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty ring corner cases and extremes
    send_item(CMD_STATUS, 8'h00, 32'h0, 1'b0);
    send_item(CMD_READ, 8'h00, 32'h0, 1'b0);
    send_item(CMD_OTHER, 8'hff, 32'hffffffff, 1'b1);
    send_item(CMD_WRITE, 8'h00, 32'h0, 1'b0);
    send_item(CMD_WRITE, 8'hff, 32'hffffffff, 1'b1);
    send_item(CMD_WRITE, 8'h5a, 32'h0, 1'b1);
    send_item(CMD_STATUS, 8'h00, 32'h0, 1'b0);
    send_item(CMD_READ, 8'h00, 32'h0, 1'b0);
    send_item(CMD_STATUS, 8'h00, 32'h0, 1'b0);
    send_item(CMD_READ, 8'h00, 32'h0, 1'b0);
    send_item(CMD_READ, 8'h00, 32'h0, 1'b0);
    send_item(CMD_READ, 8'h00, 32'h0, 1'b0);

    // bring head and tail back to zero through a wrap
    set_capacity(16'd20);
    send_item(CMD_WRITE, 8'h3c, 32'h9, 1'b1);
    send_item(CMD_READ, 8'h00, 32'h0, 1'b0);

    // zero capacity acts as one: full after one chunk
    set_capacity(16'd0);
    send_item(CMD_WRITE, 8'haa, 32'h12345678, 1'b1);
    send_item(CMD_WRITE, 8'h55, 32'h1, 1'b1);
    send_item(CMD_STATUS, 8'h00, 32'h0, 1'b0);
    send_item(CMD_READ, 8'h00, 32'h0, 1'b0);
    send_item(CMD_WRITE, 8'h55, 32'h2, 1'b1);
    set_capacity(16'd1);
    send_item(CMD_WRITE, 8'h11, 32'h3, 1'b1);
    send_item(CMD_WRITE, 8'h22, 32'h4, 1'b0);
    set_capacity(16'hffff);

    // small ring: fill to full, reject, drain through the wrap
    set_capacity(16'd40);
    for (int i = 0; i < 20; i++) send_item(CMD_WRITE, 8'($urandom), $urandom, (i % 5 == 4));
    send_item(CMD_WRITE, 8'h77, 32'h0, 1'b1);
    send_item(CMD_STATUS, 8'h00, 32'h0, 1'b0);
    for (int i = 0; i < 20; i++) send_item(CMD_READ, 8'h00, 32'h0, 1'b0);
    send_item(CMD_STATUS, 8'h00, 32'h0, 1'b0);
    random_items(60);

    caps[0] = 16'd300;
    caps[1] = 16'($urandom_range(300, 2000));
    caps[2] = 16'd61529;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 24 : (ph == 1) ? 52 : 0;
      rx_idle = (ph == 0) ? 52 : (ph == 1) ? 24 : 0;
      set_capacity(caps[ph]);
      random_items(110);
      if (ph == 1) settle();
      random_items(110);
    end

    in_if.valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending != 0) begin
      $display("tb: done, errors");
      $finish;
    end
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
